// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/pdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// pdfs_pkg
// Types, constants and helper functions for the palette dither block.
// ----------------------------------------------------------------------------
package pdfs_pkg;

   localparam int DEF_MAX_COLORS = 256;
   localparam int DEF_MAX_WIDTH  = 4096;

   localparam logic [7:0] ALPHA_LIMIT = 8'd64;
   localparam logic [7:0] CHAN_MAX    = 8'd255;

   localparam logic [1:0] REG_WIDTH   = 2'd0;
   localparam logic [1:0] REG_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_PALSIZE = 2'd2;
   localparam logic [1:0] REG_ALPHA   = 2'd3;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic [12:0] image_width;
      logic [15:0] image_height;
      logic [8:0]  palette_size;
      logic        ignore_alpha;
      logic        restart;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic mix;
      logic issue;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic kind;
      logic skip;
      logic last_issue;
      logic pipe_busy;
      logic out_hold;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MIX,
      ST_SEARCH,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // add a signed term to a channel value and clamp to 0..255
   function automatic logic [7:0] clamp_add(input logic [7:0] v, input logic signed [8:0] t);
      logic signed [9:0] s;
      s = $signed({2'b00, v}) + $signed({t[8], t});
      if (s > $signed({2'b00, CHAN_MAX})) return CHAN_MAX;
      if (s < 0) return 8'd0;
      return s[7:0];
   endfunction

   // floor(k * e / 16)
   function automatic logic signed [8:0] share(input logic [2:0] k, input logic signed [8:0] e);
      logic signed [12:0] p;
      p = $signed({{4{e[8]}}, e}) * $signed({10'b0, k});
      return p[12:4];
   endfunction

endpackage

// ===== src/pdfs_csr.sv =====
// ----------------------------------------------------------------------------
// pdfs_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module pdfs_csr import pdfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output cfg_type     cfg
);

   logic [12:0] width_ff;
   logic [15:0] height_ff;
   logic [8:0]  palsize_ff;
   logic        alpha_ff;
   logic        restart_ff;
   logic        wr;

   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 13'd128;
         height_ff  <= 16'd128;
         palsize_ff <= 9'd0;
         alpha_ff   <= 1'b0;
         restart_ff <= 1'b0;
      end else begin
         restart_ff <= 1'b0;
         if (wr) begin
            case (paddr[3:2])
               REG_WIDTH: begin
                  width_ff   <= pwdata[12:0];
                  restart_ff <= 1'b1;
               end
               REG_HEIGHT: begin
                  height_ff  <= pwdata[15:0];
                  restart_ff <= 1'b1;
               end
               REG_PALSIZE: palsize_ff <= pwdata[8:0];
               REG_ALPHA:   alpha_ff   <= pwdata[0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WIDTH:   prdata = {19'b0, width_ff};
         REG_HEIGHT:  prdata = {16'b0, height_ff};
         REG_PALSIZE: prdata = {23'b0, palsize_ff};
         REG_ALPHA:   prdata = {31'b0, alpha_ff};
         default:     prdata = 32'b0;
      endcase
   end

   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;
   assign cfg.palette_size = palsize_ff;
   assign cfg.ignore_alpha = alpha_ff;
   assign cfg.restart      = restart_ff;

endmodule

// ===== src/pdfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdfs_ctrl
// Sequencer: decode, then palette load or mix, search, drain and finish.
// ----------------------------------------------------------------------------
module pdfs_ctrl import pdfs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.kind == KIND_LOAD) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = status.skip ? ST_FINISH : ST_SEARCH;
         end
         ST_SEARCH: begin
            cmd.issue = 1'b1;
            if (status.last_issue) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_hold) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== src/pdfs_dp.sv =====
// ----------------------------------------------------------------------------
// pdfs_dp
// Datapath: palette store, line error stores, distance pipeline, diffusion.
// ----------------------------------------------------------------------------
module pdfs_dp import pdfs_pkg::*; #(
   parameter int MAX_COLORS = DEF_MAX_COLORS,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic          req_kind,
   input  logic [7:0]    req_entry_index,
   input  logic [7:0]    req_red,
   input  logic [7:0]    req_green,
   input  logic [7:0]    req_blue,
   input  logic [7:0]    req_alpha,
   input  logic [15:0]   req_entry_code,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [15:0]   rsp_pixel_code,
   output logic          rsp_too_few_colors,
   output logic          rsp_row_end
);

   localparam int PAL_DEPTH = (MAX_COLORS < 256) ? MAX_COLORS : 256;
   localparam int PA_W      = $clog2(PAL_DEPTH);
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WW        = (COL_W + 1 > 13) ? COL_W + 1 : 13;

   // request capture
   logic        kind_ff;
   logic [7:0]  idx_ff;
   logic [7:0]  col_ff [3];
   logic [7:0]  alpha_ff;
   logic [15:0] code_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         idx_ff    <= req_entry_index;
         col_ff[0] <= req_red;
         col_ff[1] <= req_green;
         col_ff[2] <= req_blue;
         alpha_ff  <= req_alpha;
         code_ff   <= req_entry_code;
      end
   end

   // geometry
   logic [WW-1:0]    w_eff;
   logic [15:0]      h_eff;
   logic [COL_W-1:0] x_ff;
   logic [15:0]      y_ff;
   logic             last_col, last_row;

   always_comb begin
      if (cfg.image_width == 13'd0) w_eff = WW'(1);
      else if (WW'(cfg.image_width) > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(cfg.image_width);
      h_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
   end

   assign last_col = WW'(x_ff) == (w_eff - WW'(1));
   assign last_row = y_ff == (h_eff - 16'd1);

   // flags
   logic few, trans, skip;
   assign few   = cfg.palette_size < 9'd2;
   assign trans = !cfg.ignore_alpha && (alpha_ff < ALPHA_LIMIT);
   assign skip  = few || trans;

   // palette store: {r, g, b, code}
   logic [39:0]     pal_mem [PAL_DEPTH];
   logic [39:0]     pal_rd_ff;
   logic [PA_W-1:0] cnt_ff;
   logic            idx_ok;
   logic [8:0]      n_eff;

   assign idx_ok = {1'b0, idx_ff} < 9'(PAL_DEPTH);
   assign n_eff  = (cfg.palette_size > 9'(PAL_DEPTH)) ? 9'(PAL_DEPTH) : cfg.palette_size;

   always_ff @(posedge clock) begin
      if (cmd.load && idx_ok)
         pal_mem[idx_ff[PA_W-1:0]] <= {col_ff[0], col_ff[1], col_ff[2], code_ff};
      pal_rd_ff <= pal_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.mix)        cnt_ff <= '0;
      else if (cmd.issue) cnt_ff <= cnt_ff + 1'b1;
   end

   // line stores: A holds {below-right, below} per channel, B the below-left share
   logic [53:0] la_mem [MAX_WIDTH];
   logic [26:0] lb_mem [MAX_WIDTH];
   logic [53:0] la_rd_ff, la_wr;
   logic [26:0] lb_rd_ff, lb_wr;

   // carries
   logic signed [8:0] rc_ff [3];
   logic signed [8:0] dg_ff [3];

   // mixed pixel
   logic [7:0] v_ff [3];
   logic [7:0] v_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         v_in[c] = col_ff[c];
         if (y_ff != 16'd0) begin
            v_in[c] = clamp_add(v_in[c], $signed(la_rd_ff[c*18+9 +: 9]));
            v_in[c] = clamp_add(v_in[c], $signed(la_rd_ff[c*18 +: 9]));
            // last column's below-left slot is never filled
            if (!last_col) v_in[c] = clamp_add(v_in[c], $signed(lb_rd_ff[c*9 +: 9]));
         end
         if (x_ff != '0) v_in[c] = clamp_add(v_in[c], rc_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mix) v_ff <= v_in;
   end

   // distance pipeline
   logic              s1_valid_ff, s2_valid_ff, have_best_ff;
   logic [39:0]       s2_ent_ff, best_ent_ff;
   logic [18:0]       s2_d_ff, best_d_ff;
   logic signed [8:0] diff [3];
   logic signed [17:0] sq [3];
   logic [18:0]       d_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff[c] = $signed({1'b0, pal_rd_ff[39-8*c -: 8]}) - $signed({1'b0, v_ff[c]});
         sq[c]   = diff[c] * diff[c];
      end
      d_in = {2'b00, sq[0][16:0]} + {2'b00, sq[1][16:0]} + {2'b00, sq[2][16:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ent_ff <= pal_rd_ff;
      s2_d_ff   <= d_in;
      if (cmd.mix) begin
         have_best_ff <= 1'b0;
      end else if (s2_valid_ff && (!have_best_ff || s2_d_ff < best_d_ff)) begin
         have_best_ff <= 1'b1;
         best_d_ff    <= s2_d_ff;
         best_ent_ff  <= s2_ent_ff;
      end
   end

   // error and shares
   logic signed [8:0] err [3];
   logic signed [8:0] sh7 [3], sh5 [3], sh3 [3], sh1 [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (skip) err[c] = '0;
         else err[c] = $signed({1'b0, v_ff[c]}) - $signed({1'b0, best_ent_ff[39-8*c -: 8]});
         sh7[c] = share(3'd7, err[c]);
         sh5[c] = share(3'd5, err[c]);
         sh3[c] = share(3'd3, err[c]);
         sh1[c] = share(3'd1, err[c]);
         la_wr[c*18 +: 18] = {dg_ff[c], sh5[c]};
         lb_wr[c*9 +: 9]   = sh3[c];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && !last_row) begin
         la_mem[x_ff] <= la_wr;
         if (x_ff != '0) lb_mem[x_ff - 1'b1] <= lb_wr;
      end
      la_rd_ff <= la_mem[x_ff];
      lb_rd_ff <= lb_mem[x_ff];
   end

   // raster position and carries
   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         x_ff <= '0;
         y_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            rc_ff[c] <= '0;
            dg_ff[c] <= '0;
         end
      end else if (cmd.finish) begin
         for (int c = 0; c < 3; c++) begin
            rc_ff[c] <= last_col ? 9'sd0 : sh7[c];
            dg_ff[c] <= (last_col || last_row) ? 9'sd0 : sh1[c];
         end
         if (last_col) begin
            x_ff <= '0;
            y_ff <= last_row ? 16'd0 : y_ff + 16'd1;
         end else begin
            x_ff <= x_ff + 1'b1;
         end
      end
   end

   // output register
   logic        out_valid_ff;
   logic [15:0] out_code_ff;
   logic        out_few_ff, out_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         out_code_ff <= skip ? 16'd0 : best_ent_ff[15:0];
         out_few_ff  <= few;
         out_end_ff  <= last_col;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_pixel_code     = out_code_ff;
   assign rsp_too_few_colors = out_few_ff;
   assign rsp_row_end        = out_end_ff;

   assign status.kind       = kind_ff;
   assign status.skip       = skip;
   assign status.last_issue = {{(9-PA_W){1'b0}}, cnt_ff} == (n_eff - 9'd1);
   assign status.pipe_busy  = s1_valid_ff || s2_valid_ff;
   assign status.out_hold   = out_valid_ff && rsp_stall;

endmodule

// ===== src/palette_dither_floyd_steinberg.sv =====
// ----------------------------------------------------------------------------
// palette_dither_floyd_steinberg
// Nearest-palette mapping of raster RGBA pixels with Floyd-Steinberg diffusion.
// ----------------------------------------------------------------------------
//  channel   ports                 direction  moves
//  request   req_valid/req_stall   in         palette load or pixel
//  response  rsp_valid/rsp_stall   out        pixel code, flags
//  config    psel..pready (APB)    in/out     register access
//
// A load is written in decode. A searched pixel passes mix, search, drain
// and finish, which registers its response and frees the block. Search
// reads n = active entries (min of palette_size and MAX_COLORS, 256), one
// per cycle. Transparent pixels or a too-small palette skip search and
// drain. No clearing pass after reset. A stalled response holds in the
// output register; the next request is accepted but cannot finish.
module palette_dither_floyd_steinberg import pdfs_pkg::*; #(
   parameter int MAX_COLORS = DEF_MAX_COLORS,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_alpha,
   input  logic [15:0] req_entry_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pixel_code,
   output logic        rsp_too_few_colors,
   output logic        rsp_row_end,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign pready = 1'b1;

   pdfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   pdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pdfs_dp #(
      .MAX_COLORS (MAX_COLORS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_kind),
      .req_entry_index    (req_entry_index),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_alpha          (req_alpha),
      .req_entry_code     (req_entry_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_code     (rsp_pixel_code),
      .rsp_too_few_colors (rsp_too_few_colors),
      .rsp_row_end        (rsp_row_end)
   );

endmodule

// ===== src/pdfs_checker.sv =====
// ----------------------------------------------------------------------------
// pdfs_checker
// Port-level checks on the palette dither block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_pixel_code,
   input logic        rsp_too_few_colors
);

   // held response keeps its code
   `AST_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_code))

   // one request at a time: busy right after an accept
   `AST_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // a flagged palette never yields a code
   `AST_IMPLY(a_few_zero, clock, reset, rsp_valid && rsp_too_few_colors, rsp_pixel_code == 16'd0)

   // no response straight out of reset
   `AST_IMPLY(a_reset_quiet, clock, reset, $past(reset), !rsp_valid)

endmodule

bind palette_dither_floyd_steinberg pdfs_checker u_pdfs_checker (.*);
